/* rtl/core/dual_slot_charge_supervisor_core_defines.svh */
// ----------------------------------------------------------------------------
// Assertion macros for the dual slot charge supervisor
// Concurrent checks that compile away when SYNTHESIS is defined
// ----------------------------------------------------------------------------
`ifndef DUAL_SLOT_CHARGE_SUPERVISOR_CORE_DEFINES_SVH
`define DUAL_SLOT_CHARGE_SUPERVISOR_CORE_DEFINES_SVH

`ifndef SYNTHESIS
`define DSSC_ASSERT(lbl, clk, rstn, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (prop)) else $error(msg);
`define DSSC_NEVER(lbl, clk, rstn, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) !(cond)) else $error(msg);
`else
`define DSSC_ASSERT(lbl, clk, rstn, prop, msg)
`define DSSC_NEVER(lbl, clk, rstn, cond, msg)
`endif

`endif

/* rtl/core/dssc_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// dssc_pkg
// Types, codes and constants of the dual slot charge supervisor
// ----------------------------------------------------------------------------
package dssc_pkg;

  localparam int SLOTS = 2;
  localparam int AGE_W = 16;
  localparam int SOC_W = 7;
  localparam int MV_W  = 16;
  localparam int MA_W  = 16;
  localparam int PROT_W = 16;
  localparam int CFG_W = 16;
  localparam int CFG_IDX_W = 3;
  localparam int S_DATA_W = 64;
  localparam int S_USER_W = 2;
  localparam int M_DATA_W = 16;

  localparam logic [AGE_W-1:0] AGE_MAX = '1;

  localparam logic [SOC_W-1:0] RST_MAX_SOC   = 7'd100;
  localparam logic [MV_W-1:0]  RST_MAX_MV    = 16'd54600;
  localparam logic [AGE_W-1:0] RST_ESTOP_DB  = 16'd80;
  localparam logic [AGE_W-1:0] RST_TOGGLE_DB = 16'd50;
  localparam logic [AGE_W-1:0] RST_ZC_FAULT  = 16'd15000;

  typedef enum logic [1:0] {
    ACT_NONE    = 2'd0,
    ACT_ENABLE  = 2'd1,
    ACT_DISABLE = 2'd2
  } act_e;

  typedef enum logic {
    CMD_TICK   = 1'b0,
    CMD_REPORT = 1'b1
  } cmd_e;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_MAX_SOC      = 3'd0,
    CFG_MAX_MV       = 3'd1,
    CFG_ESTOP_DB     = 3'd2,
    CFG_TOGGLE_DB    = 3'd3,
    CFG_ZC_FAULT     = 3'd4,
    CFG_ESTOP_LEVEL  = 3'd5,
    CFG_TOGGLE_LEVEL = 3'd6,
    CFG_SW_CUTOFF    = 3'd7
  } cfg_idx_e;

  typedef struct packed {
    logic             connected;
    logic [SOC_W-1:0] soc;
    logic [MV_W-1:0]  mv;
    logic             cur_pos;
    logic             prot;
  } slot_status_t;

  function automatic logic is_full(input logic [SOC_W-1:0] soc,
                                   input logic [MV_W-1:0]  mv,
                                   input logic [SOC_W-1:0] max_soc,
                                   input logic [MV_W-1:0]  max_mv);
    return (soc >= max_soc) || (mv >= max_mv);
  endfunction

  function automatic logic [AGE_W-1:0] age_inc(input logic [AGE_W-1:0] age);
    return (age == AGE_MAX) ? age : age + AGE_W'(1);
  endfunction

endpackage
`default_nettype wire

/* rtl/core/dual_slot_charge_supervisor_core.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// dual_slot_charge_supervisor_core
// Debounce, enable tracking, recovery and fault timing for two charge slots
// ----------------------------------------------------------------------------
// Every accepted word (a 1 ms tick with raw pin levels, or a monitor report
// for one slot) produces exactly one result word. A word is registered in the
// input register on acceptance, evaluated against the supervisor state once the
// output register is free or being read, and its result lands in the output
// register, from which the consumer takes it.
// One word can be accepted every clock cycle while the consumer keeps up;
// the state update loop sets that rate, and the output register lets one more
// word into the input register while a finished result waits for its consumer.
// Configuration writes take effect at the clock edge at which cfg_we_i is high.
`include "dual_slot_charge_supervisor_core_defines.svh"

module dual_slot_charge_supervisor_core (
  input  wire logic                            clk_i,
  input  wire logic                            rst_ni,
  input  wire logic                            s_axis_tvalid_i,
  output      logic                            s_axis_tready_o,
  // estop_pins, toggle_pins, link_ok, connected, state_of_charge, pack_mv,
  // pack_ma, protection_flags, mosfet_on
  input  wire logic [dssc_pkg::S_DATA_W-1:0]   s_axis_tdata_i,
  // command, slot
  input  wire logic [dssc_pkg::S_USER_W-1:0]   s_axis_tuser_i,
  output      logic                            m_axis_tvalid_o,
  input  wire logic                            m_axis_tready_i,
  // action, emergency_stop, enabled_slots, fault_slots, recovery_slots
  output      logic [dssc_pkg::M_DATA_W-1:0]   m_axis_tdata_o,
  // action_slot
  output      logic                            m_axis_tuser_o,
  input  wire logic                            cfg_we_i,
  input  wire logic [dssc_pkg::CFG_IDX_W-1:0]  cfg_index_i,
  input  wire logic [dssc_pkg::CFG_W-1:0]      cfg_data_i
);

  localparam int NS = dssc_pkg::SLOTS;
  localparam int AW = dssc_pkg::AGE_W;

  // configuration
  logic [dssc_pkg::SOC_W-1:0] cfg_max_soc_q;
  logic [dssc_pkg::MV_W-1:0]  cfg_max_mv_q;
  logic [AW-1:0]              cfg_estop_db_q;
  logic [AW-1:0]              cfg_toggle_db_q;
  logic [AW-1:0]              cfg_zc_fault_q;
  logic                       cfg_estop_lvl_q;
  logic                       cfg_toggle_lvl_q;
  logic                       cfg_sw_cutoff_q;

  // input stage
  logic                            in_vld_q, in_vld_d;
  logic [dssc_pkg::S_DATA_W-1:0]   in_data_q;
  logic [dssc_pkg::S_USER_W-1:0]   in_user_q;
  logic                            advance;
  logic                            s_accept;

  // decoded input word
  dssc_pkg::cmd_e              in_cmd;
  logic                        in_slot;
  logic [1:0]                  in_estop_pins;
  logic [1:0]                  in_toggle_pins;
  logic                        in_link_ok;
  logic                        in_connected;
  logic [dssc_pkg::SOC_W-1:0]  in_soc;
  logic [dssc_pkg::MV_W-1:0]   in_mv;
  logic [dssc_pkg::MA_W-1:0]   in_ma;
  logic [dssc_pkg::PROT_W-1:0] in_prot;
  logic                        in_mosfet;

  // supervisor state
  logic          estop_last_q, estop_last_d;
  logic          estop_stable_q, estop_stable_d;
  logic [AW-1:0] estop_age_q, estop_age_d;
  logic          stop_last_q, stop_last_d;
  logic [NS-1:0] tog_last_q, tog_last_d;
  logic [NS-1:0] tog_stable_q, tog_stable_d;
  logic [AW-1:0] tog_age_q [NS];
  logic [AW-1:0] tog_age_d [NS];
  logic [NS-1:0] en_q, en_d;
  logic [NS-1:0] rec_q, rec_d;
  logic [AW-1:0] zc_age_q [NS];
  logic [AW-1:0] zc_age_d [NS];
  logic [NS-1:0] zc_run_q, zc_run_d;
  logic [NS-1:0] fault_q, fault_d;
  dssc_pkg::slot_status_t status_q [NS];
  dssc_pkg::slot_status_t status_d [NS];

  // working values
  logic                   estop_raw;
  logic                   stop_now;
  logic [NS-1:0]          tog_raw;
  logic [NS-1:0]          clr_cond;
  dssc_pkg::slot_status_t rpt_stat;
  logic                   rpt_full;
  dssc_pkg::act_e         act;

  // result stage
  logic           out_vld_q;
  dssc_pkg::act_e res_act_q;
  logic           res_slot_q;
  logic           res_stop_q;
  logic [NS-1:0]  res_en_q;
  logic [NS-1:0]  res_fault_q;
  logic [NS-1:0]  res_rec_q;

  assign advance         = in_vld_q && (!out_vld_q || m_axis_tready_i);
  assign s_axis_tready_o = !in_vld_q || advance;
  assign s_accept        = s_axis_tvalid_i && s_axis_tready_o;

  always_comb begin
    in_vld_d = in_vld_q;
    if (s_accept) begin
      in_vld_d = 1'b1;
    end else if (advance) begin
      in_vld_d = 1'b0;
    end
  end

  assign in_cmd         = dssc_pkg::cmd_e'(in_user_q[0]);
  assign in_slot        = in_user_q[1];
  assign in_estop_pins  = in_data_q[1:0];
  assign in_toggle_pins = in_data_q[3:2];
  assign in_link_ok     = in_data_q[4];
  assign in_connected   = in_data_q[5];
  assign in_soc         = in_data_q[12:6];
  assign in_mv          = in_data_q[28:13];
  assign in_ma          = in_data_q[44:29];
  assign in_prot        = in_data_q[60:45];
  assign in_mosfet      = in_data_q[61];

  always_comb begin
    rpt_stat.connected = in_connected;
    rpt_stat.soc       = in_soc;
    rpt_stat.mv        = in_mv;
    rpt_stat.cur_pos   = (in_ma != '0) && !in_ma[dssc_pkg::MA_W-1];
    rpt_stat.prot      = (in_prot != '0);
  end

  assign rpt_full = dssc_pkg::is_full(in_soc, in_mv, cfg_max_soc_q, cfg_max_mv_q);

  always_comb begin
    estop_last_d   = estop_last_q;
    estop_stable_d = estop_stable_q;
    estop_age_d    = estop_age_q;
    stop_last_d    = stop_last_q;
    tog_last_d     = tog_last_q;
    tog_stable_d   = tog_stable_q;
    en_d           = en_q;
    rec_d          = rec_q;
    zc_run_d       = zc_run_q;
    fault_d        = fault_q;
    for (int i = 0; i < NS; i++) begin
      tog_age_d[i] = tog_age_q[i];
      zc_age_d[i]  = zc_age_q[i];
      status_d[i]  = status_q[i];
    end
    act       = dssc_pkg::ACT_NONE;
    estop_raw = (in_estop_pins[0] == cfg_estop_lvl_q) || (in_estop_pins[1] == cfg_estop_lvl_q);
    stop_now  = 1'b0;
    tog_raw   = '0;
    clr_cond  = '0;

    if (advance) begin
      if (in_cmd == dssc_pkg::CMD_TICK) begin
        // emergency debounce
        if (estop_raw != estop_last_q) begin
          estop_last_d = estop_raw;
          estop_age_d  = '0;
        end else begin
          estop_age_d = dssc_pkg::age_inc(estop_age_q);
        end
        if (estop_age_d >= cfg_estop_db_q) begin
          estop_stable_d = estop_last_d;
        end
        stop_now = estop_stable_d && (|en_q);

        // toggle debounce and enables
        for (int i = 0; i < NS; i++) begin
          tog_raw[i] = (in_toggle_pins[i] == cfg_toggle_lvl_q);
          if (tog_raw[i] != tog_last_q[i]) begin
            tog_last_d[i] = tog_raw[i];
            tog_age_d[i]  = '0;
          end else begin
            tog_age_d[i] = dssc_pkg::age_inc(tog_age_q[i]);
          end
          if (tog_age_d[i] >= cfg_toggle_db_q) begin
            tog_stable_d[i] = tog_last_d[i];
          end
          en_d[i] = tog_stable_d[i];
          if (en_q[i] && !en_d[i]) begin
            rec_d[i] = 1'b0;
          end
        end

        // release arms recovery
        if (stop_last_q && !stop_now) begin
          rec_d = en_d;
        end

        // zero current fault timer
        for (int i = 0; i < NS; i++) begin
          clr_cond[i] = !en_d[i] || !status_q[i].connected ||
                        dssc_pkg::is_full(status_q[i].soc, status_q[i].mv,
                                          cfg_max_soc_q, cfg_max_mv_q) ||
                        (!status_q[i].prot && status_q[i].cur_pos);
          if (clr_cond[i]) begin
            zc_age_d[i] = '0;
            zc_run_d[i] = 1'b0;
            fault_d[i]  = 1'b0;
          end else if (status_q[i].prot) begin
            fault_d[i] = 1'b1;
          end else begin
            if (!zc_run_q[i]) begin
              zc_run_d[i] = 1'b1;
              zc_age_d[i] = '0;
            end else begin
              zc_age_d[i] = dssc_pkg::age_inc(zc_age_q[i]);
            end
            fault_d[i] = (zc_age_d[i] >= cfg_zc_fault_q);
          end
        end

        stop_last_d = stop_now;
      end else begin
        status_d[in_slot] = rpt_stat;
        if (!in_link_ok || !in_connected) begin
          act = dssc_pkg::ACT_NONE;
        end else if (stop_last_q && cfg_sw_cutoff_q && in_mosfet) begin
          act = dssc_pkg::ACT_DISABLE;
        end else if (!en_q[in_slot] || rpt_full) begin
          rec_d[in_slot] = 1'b0;
          act = in_mosfet ? dssc_pkg::ACT_DISABLE : dssc_pkg::ACT_NONE;
        end else if (rec_q[in_slot]) begin
          if (!in_mosfet) begin
            act = dssc_pkg::ACT_ENABLE;
          end else begin
            rec_d[in_slot] = 1'b0;
            act = dssc_pkg::ACT_NONE;
          end
        end else begin
          act = in_mosfet ? dssc_pkg::ACT_NONE : dssc_pkg::ACT_ENABLE;
        end
      end
    end
  end

  // configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_max_soc_q    <= dssc_pkg::RST_MAX_SOC;
      cfg_max_mv_q     <= dssc_pkg::RST_MAX_MV;
      cfg_estop_db_q   <= dssc_pkg::RST_ESTOP_DB;
      cfg_toggle_db_q  <= dssc_pkg::RST_TOGGLE_DB;
      cfg_zc_fault_q   <= dssc_pkg::RST_ZC_FAULT;
      cfg_estop_lvl_q  <= 1'b0;
      cfg_toggle_lvl_q <= 1'b0;
      cfg_sw_cutoff_q  <= 1'b0;
    end else if (cfg_we_i) begin
      case (dssc_pkg::cfg_idx_e'(cfg_index_i))
        dssc_pkg::CFG_MAX_SOC:      cfg_max_soc_q    <= cfg_data_i[dssc_pkg::SOC_W-1:0];
        dssc_pkg::CFG_MAX_MV:       cfg_max_mv_q     <= cfg_data_i[dssc_pkg::MV_W-1:0];
        dssc_pkg::CFG_ESTOP_DB:     cfg_estop_db_q   <= cfg_data_i[AW-1:0];
        dssc_pkg::CFG_TOGGLE_DB:    cfg_toggle_db_q  <= cfg_data_i[AW-1:0];
        dssc_pkg::CFG_ZC_FAULT:     cfg_zc_fault_q   <= cfg_data_i[AW-1:0];
        dssc_pkg::CFG_ESTOP_LEVEL:  cfg_estop_lvl_q  <= cfg_data_i[0];
        dssc_pkg::CFG_TOGGLE_LEVEL: cfg_toggle_lvl_q <= cfg_data_i[0];
        dssc_pkg::CFG_SW_CUTOFF:    cfg_sw_cutoff_q  <= cfg_data_i[0];
        default: ;
      endcase
    end
  end

  // input register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q <= 1'b0;
    end else begin
      in_vld_q <= in_vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_accept) begin
      in_data_q <= s_axis_tdata_i;
      in_user_q <= s_axis_tuser_i;
    end
  end

  // supervisor state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      estop_last_q   <= 1'b0;
      estop_stable_q <= 1'b0;
      estop_age_q    <= '0;
      stop_last_q    <= 1'b0;
      tog_last_q     <= '0;
      tog_stable_q   <= '0;
      en_q           <= '0;
      rec_q          <= '0;
      zc_run_q       <= '0;
      fault_q        <= '0;
      for (int i = 0; i < NS; i++) begin
        tog_age_q[i] <= '0;
        zc_age_q[i]  <= '0;
        status_q[i]  <= '0;
      end
    end else begin
      estop_last_q   <= estop_last_d;
      estop_stable_q <= estop_stable_d;
      estop_age_q    <= estop_age_d;
      stop_last_q    <= stop_last_d;
      tog_last_q     <= tog_last_d;
      tog_stable_q   <= tog_stable_d;
      en_q           <= en_d;
      rec_q          <= rec_d;
      zc_run_q       <= zc_run_d;
      fault_q        <= fault_d;
      for (int i = 0; i < NS; i++) begin
        tog_age_q[i] <= tog_age_d[i];
        zc_age_q[i]  <= zc_age_d[i];
        status_q[i]  <= status_d[i];
      end
    end
  end

  // result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else if (advance) begin
      out_vld_q <= 1'b1;
    end else if (m_axis_tready_i) begin
      out_vld_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance) begin
      res_act_q   <= act;
      res_slot_q  <= (in_cmd == dssc_pkg::CMD_REPORT) ? in_slot : 1'b0;
      res_stop_q  <= stop_last_d;
      res_en_q    <= en_d;
      res_fault_q <= fault_d;
      res_rec_q   <= rec_d;
    end
  end

  assign m_axis_tvalid_o = out_vld_q;
  assign m_axis_tuser_o  = res_slot_q;
  assign m_axis_tdata_o  = {7'd0, res_rec_q, res_fault_q, res_en_q, res_stop_q, res_act_q};

  // checks
  `DSSC_NEVER(a_fault_needs_en, clk_i, rst_ni, (fault_q & ~en_q) != '0, "fault on disabled slot")
  `DSSC_NEVER(a_rec_needs_en, clk_i, rst_ni, (rec_q & ~en_q) != '0, "recovery on disabled slot")
  `DSSC_ASSERT(a_stop_stable, clk_i, rst_ni, stop_last_q |-> estop_stable_q, "stop without estop")
  `DSSC_ASSERT(a_in_hold, clk_i, rst_ni, (in_vld_q && !advance) |=> in_vld_q, "input word lost")

endmodule
`default_nettype wire
